/* rtl/pmst_pkg.sv */
package pmst_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int WEIGHT_BITS  = 16;
    localparam int VIDX_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = VIDX_BITS + 1;
    localparam int KEY_BITS     = WEIGHT_BITS + 1;
    localparam int WADDR_BITS   = 2 * VIDX_BITS;

    localparam logic [KEY_BITS-1:0] KEY_INF = KEY_BITS'(1) << WEIGHT_BITS;
    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_VERTICES);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic                   action;
        logic [VIDX_BITS-1:0]   row;
        logic [VIDX_BITS-1:0]   col;
        logic [WEIGHT_BITS-1:0] weight;
    } t_request;

    typedef struct packed {
        logic [VIDX_BITS-1:0]   vertex;
        logic [VIDX_BITS-1:0]   parent;
        logic [WEIGHT_BITS-1:0] edge_weight;
        logic                   is_root;
        logic                   reachable;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic                   in_tree;
        logic [KEY_BITS-1:0]    key;
        logic [VIDX_BITS-1:0]   parent;
    } t_vstate;

    // 0 behaves as 1, anything past the array size as the array size
    function automatic logic [CNT_BITS-1:0] eff_count(input logic [CNT_BITS-1:0] c);
        logic [CNT_BITS-1:0] r;
        r = c;
        if (c == '0) begin
            r = CNT_BITS'(1);
        end else if (c > CNT_MAX) begin
            r = CNT_MAX;
        end
        return r;
    endfunction

endpackage

/* rtl/pmst_ram.sv */
module pmst_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [(1 << ADDR_BITS)];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pmst_engine.sv */
module pmst_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start_run,
    input  logic [pmst_pkg::CNT_BITS-1:0]       i_count,
    output logic                                o_busy,
    output logic [pmst_pkg::WADDR_BITS-1:0]     o_w_raddr,
    input  logic [pmst_pkg::WEIGHT_BITS-1:0]    i_w_rdata,
    output logic                                o_result_valid,
    output pmst_pkg::t_result                   o_result
);
    import pmst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_PASS,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [CNT_BITS-1:0]    r_n;
    logic [CNT_BITS-1:0]    r_idx;
    logic [CNT_BITS-1:0]    r_step;
    logic                   r_vld_d;
    logic [VIDX_BITS-1:0]   r_v_d;
    logic [VIDX_BITS-1:0]   r_pick;
    logic                   r_found;
    logic [KEY_BITS-1:0]    r_best;
    logic [VIDX_BITS-1:0]   r_best_idx;
    logic                   r_best_ok;
    logic [VIDX_BITS-1:0]   r_free_idx;
    logic                   r_free_ok;
    logic                   r_out_valid;
    t_result                r_out;

    t_vstate                r_vmem [MAX_VERTICES];
    t_vstate                r_rd_state;

    logic                   s_issue;
    logic                   s_is_pick;
    logic                   s_unvis;
    logic                   s_relax;
    logic [KEY_BITS-1:0]    s_new_key;
    logic [VIDX_BITS-1:0]   s_new_parent;
    logic                   s_we;
    logic [VIDX_BITS-1:0]   s_waddr;
    t_vstate                s_wdata;
    logic                   s_root;
    logic                   s_reach;

    assign s_issue   = (r_idx < r_n);
    assign s_is_pick = (r_v_d == r_pick);
    assign s_unvis   = !r_rd_state.in_tree && !s_is_pick;
    assign s_relax   = r_found && s_unvis && (i_w_rdata != '0)
                       && ({1'b0, i_w_rdata} < r_rd_state.key);
    assign s_new_key    = s_relax ? {1'b0, i_w_rdata} : r_rd_state.key;
    assign s_new_parent = s_relax ? r_pick : r_rd_state.parent;

    assign s_root  = (r_v_d == '0);
    assign s_reach = (r_rd_state.key < KEY_INF);

    // one write a cycle: clearing sweep, or the write-back of the relax pass
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_v_d;
        s_wdata = '{in_tree: r_rd_state.in_tree | s_is_pick,
                    key: s_new_key, parent: s_new_parent};
        if (r_state == S_CLEAR) begin
            s_we    = s_issue;
            s_waddr = r_idx[VIDX_BITS-1:0];
            s_wdata = '{in_tree: 1'b0,
                        key: (r_idx == '0) ? '0 : KEY_INF,
                        parent: '0};
        end else if (r_state == S_PASS) begin
            s_we = r_vld_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_vmem[s_waddr] <= s_wdata;
        end
        r_rd_state <= r_vmem[r_idx[VIDX_BITS-1:0]];
    end

    assign o_w_raddr = {r_pick, r_idx[VIDX_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= CNT_BITS'(1);
            r_idx       <= '0;
            r_step      <= '0;
            r_vld_d     <= 1'b0;
            r_v_d       <= '0;
            r_pick      <= '0;
            r_found     <= 1'b0;
            r_best      <= KEY_INF;
            r_best_idx  <= '0;
            r_best_ok   <= 1'b0;
            r_free_idx  <= '0;
            r_free_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_vld_d     <= 1'b0;
            r_v_d       <= r_idx[VIDX_BITS-1:0];
            case (r_state)
                S_IDLE: begin
                    if (i_start_run) begin
                        r_n     <= i_count;
                        r_idx   <= '0;
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    if (s_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_idx     <= '0;
                        r_step    <= '0;
                        r_pick    <= '0;
                        r_found   <= 1'b1;
                        r_best    <= KEY_INF;
                        r_best_ok <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state   <= S_PASS;
                    end
                end
                S_PASS: begin
                    if (s_issue) begin
                        r_idx   <= r_idx + 1'b1;
                        r_vld_d <= 1'b1;
                    end
                    if (r_vld_d && s_unvis) begin
                        // strict less-than keeps ties on the lower index
                        if (s_new_key < r_best) begin
                            r_best     <= s_new_key;
                            r_best_idx <= r_v_d;
                            r_best_ok  <= 1'b1;
                        end
                        if (!r_free_ok) begin
                            r_free_idx <= r_v_d;
                            r_free_ok  <= 1'b1;
                        end
                    end
                    if (!s_issue && !r_vld_d) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_idx     <= '0;
                    r_best    <= KEY_INF;
                    r_best_ok <= 1'b0;
                    r_free_ok <= 1'b0;
                    if (r_step == r_n - 1'b1) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_pick  <= r_best_ok ? r_best_idx : r_free_idx;
                        r_found <= r_best_ok;
                        r_state <= S_PASS;
                    end
                end
                S_EMIT: begin
                    if (s_issue) begin
                        r_idx   <= r_idx + 1'b1;
                        r_vld_d <= 1'b1;
                    end
                    if (r_vld_d) begin
                        r_out_valid       <= 1'b1;
                        r_out.vertex      <= r_v_d;
                        r_out.parent      <= (s_root || !s_reach) ? '0 : r_rd_state.parent;
                        r_out.edge_weight <= (s_root || !s_reach)
                                             ? '0 : r_rd_state.key[WEIGHT_BITS-1:0];
                        r_out.is_root     <= s_root;
                        r_out.reachable   <= s_reach;
                        r_out.last        <= ({1'b0, r_v_d} == r_n - 1'b1);
                    end
                    if (!s_issue && !r_vld_d) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == S_EMIT))
        else $error("result strobe outside the emit phase");

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS && r_vld_d && s_issue) |-> (r_v_d != r_idx[VIDX_BITS-1:0]))
        else $error("write-back and read hit the same vertex entry");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |-> ({1'b0, r_pick} < r_n))
        else $error("picked vertex outside the active count");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |=> !r_out_valid)
        else $error("result after the last vertex");

endmodule

/* rtl/prim_minimum_spanning_tree_unit.sv */
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        i_request (t_request)
// result    out        o_result_valid       o_result (t_result), one cycle each
// config    in/out     psel/penable/pwrite  paddr, pwdata, prdata; pready tied high
//
// A load request writes the matrix memory at the accepting edge; busy stays low.
// A run keeps busy high for n vertices in use through a clearing sweep,
// n passes over the vertex-state memory, and an emit phase that carries
// the results back to back.
// Reset is synchronous, active low; the matrix holds no reset value.
// Results cannot be stalled by the receiver.
module prim_minimum_spanning_tree_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pmst_pkg::t_request   i_request,
    output logic                 o_result_valid,
    output pmst_pkg::t_result    o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import pmst_pkg::*;

    logic [CNT_BITS-1:0]    r_vertex_count;
    logic [CNT_BITS-1:0]    s_n;
    logic                   s_accept;
    logic                   s_load_we;
    logic [WADDR_BITS-1:0]  s_w_raddr;
    logic [WEIGHT_BITS-1:0] s_w_rdata;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= CNT_MAX;
        end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
            r_vertex_count <= pwdata[CNT_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT)
                    ? {{(32 - CNT_BITS){1'b0}}, r_vertex_count} : '0;

    assign s_n       = eff_count(r_vertex_count);
    assign s_accept  = start && !busy;
    assign s_load_we = s_accept && (i_request.action == ACT_LOAD)
                       && ({1'b0, i_request.row} < s_n)
                       && ({1'b0, i_request.col} < s_n);

    pmst_ram #(
        .ADDR_BITS (WADDR_BITS),
        .DATA_BITS (WEIGHT_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (s_load_we),
        .i_waddr ({i_request.row, i_request.col}),
        .i_wdata (i_request.weight),
        .i_raddr (s_w_raddr),
        .o_rdata (s_w_rdata)
    );

    pmst_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_run    (s_accept && (i_request.action == ACT_RUN)),
        .i_count        (s_n),
        .o_busy         (busy),
        .o_w_raddr      (s_w_raddr),
        .i_w_rdata      (s_w_rdata),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
